[hw/rtl/fsfp_pkg.sv]
package fsfp_pkg;

  localparam int TICK_W     = 64;
  localparam int HALF_W     = TICK_W / 2;
  localparam int K_W        = 34;
  localparam int USEC_W     = 31;
  localparam int JERK_W     = 32;
  localparam int FRAC_SHIFT = 33;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USEC_PER_TICK = 2'd1;

  // Stage enables for one tick-to-microsecond converter.
  typedef struct packed {
    logic pp_en;
    logic out_en;
  } fsfp_conv_ctl_t;

endpackage

[hw/rtl/fsfp_in_if.sv]
interface fsfp_in_if;
  logic                        valid;
  logic                        ready;
  logic [fsfp_pkg::TICK_W-1:0] now_ticks;
  logic                        restart;

  modport source (output valid, output now_ticks, output restart, input ready);
  modport sink (input valid, input now_ticks, input restart, output ready);
endinterface

[hw/rtl/fsfp_out_if.sv]
interface fsfp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        advanced;
  logic [fsfp_pkg::USEC_W-1:0] sleep_usec;
  logic [fsfp_pkg::USEC_W-1:0] elapsed_usec;
  logic [fsfp_pkg::JERK_W-1:0] jerk_count;

  modport source (output valid, output advanced, output sleep_usec,
                  output elapsed_usec, output jerk_count, input ready);
  modport sink (input valid, input advanced, input sleep_usec,
                input elapsed_usec, input jerk_count, output ready);
endinterface

[hw/rtl/fsfp_usec_conv.sv]
module fsfp_usec_conv (
  input  logic                          clk,
  input  fsfp_pkg::fsfp_conv_ctl_t      ctl,
  input  logic [fsfp_pkg::TICK_W-1:0]   delta,
  input  logic [fsfp_pkg::K_W-1:0]      usec_per_tick,
  output logic [fsfp_pkg::USEC_W-1:0]   usec
);
  import fsfp_pkg::*;

  localparam int KHI_W = K_W - HALF_W;

  logic [HALF_W-1:0]        d_lo, d_hi, k_lo;
  logic [KHI_W-1:0]         k_hi;
  logic [TICK_W-1:0]        m_lo, m_mid;
  logic [HALF_W+KHI_W-1:0]  m_hk;
  logic [TICK_W-1:0]        pp_lo_r;
  logic [HALF_W-1:0]        pp_mid_r, pp_hk_r;
  logic [HALF_W-1:0]        mid_sum;
  logic [TICK_W-1:0]        prod;
  logic [USEC_W-1:0]        usec_r;

  assign d_lo = delta[HALF_W-1:0];
  assign d_hi = delta[TICK_W-1:HALF_W];
  assign k_lo = usec_per_tick[HALF_W-1:0];
  assign k_hi = usec_per_tick[K_W-1:HALF_W];

  // Only the low 64 bits of the product are kept, so the high-by-high term
  // drops out and the cross terms contribute only their low halves.
  assign m_lo  = TICK_W'(d_lo) * TICK_W'(k_lo);
  assign m_mid = TICK_W'(d_hi) * TICK_W'(k_lo);
  assign m_hk  = (HALF_W+KHI_W)'(d_lo) * (HALF_W+KHI_W)'(k_hi);

  always_ff @(posedge clk) begin
    if (ctl.pp_en) begin
      pp_lo_r  <= m_lo;
      pp_mid_r <= m_mid[HALF_W-1:0];
      pp_hk_r  <= m_hk[HALF_W-1:0];
    end
  end

  assign mid_sum = pp_mid_r + pp_hk_r;
  assign prod    = pp_lo_r + {mid_sum, {HALF_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (ctl.out_en) begin
      usec_r <= prod[FRAC_SHIFT +: USEC_W];
    end
  end

  assign usec = usec_r;

endmodule

[hw/rtl/fixed_step_frame_pacer.sv]
// Channel    Dir  Payload                                          Transfer
// in_item    in   now_ticks[63:0], restart                         valid & ready
// out_result out  advanced, sleep_usec, elapsed_usec, jerk_count   valid & ready
// cfg_*      in   cfg_index[1:0], cfg_data[63:0]                   cfg_we
//
// One transaction is accepted per cycle unless the output stalls. Frame state
// is updated in the accept cycle from 64-bit adds, subtracts and two compares;
// the two tick-to-microsecond conversions follow in a two-stage multiplier
// pipeline. Synchronous reset clears configuration, frame state and valid
// flags. A stalled output holds the pipeline, which still fills empty stages.
module fixed_step_frame_pacer (
  input  logic                             clk,
  input  logic                             rst_n,
  fsfp_in_if.sink                          in_item,
  fsfp_out_if.source                       out_result,
  input  logic                             cfg_we,
  input  logic [fsfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fsfp_pkg::TICK_W-1:0]      cfg_data
);
  import fsfp_pkg::*;

  localparam logic [JERK_W-1:0] JERK_MAX = '1;

  // Configuration and frame state.
  logic [TICK_W-1:0] step_r;
  logic [K_W-1:0]    k_r;
  logic [TICK_W-1:0] frame_clock_r, frame_clock_nxt;
  logic [TICK_W-1:0] next_r, next_nxt;
  logic [TICK_W-1:0] mark_r, mark_nxt;
  logic [JERK_W-1:0] jerks_r, jerks_nxt;

  // Pipeline.
  logic              s1_v_r, s2_v_r, out_v_r;
  logic              s1_adv_r, s2_adv_r, out_adv_r;
  logic [JERK_W-1:0] s1_jerk_r, s2_jerk_r, out_jerk_r;
  logic [TICK_W-1:0] s1_sleep_d_r, s1_elap_d_r;

  logic s3_free, s2_free, s1_free, in_acc;
  logic [TICK_W-1:0] wait_diff, late_diff, now_plus_step, next_plus_step;
  logic              is_wait, in_cadence, advance;
  fsfp_conv_ctl_t    conv_ctl;
  logic [USEC_W-1:0] sleep_usec, elapsed_usec;

  assign s3_free = !out_v_r || out_result.ready;
  assign s2_free = !s2_v_r || s3_free;
  assign s1_free = !s1_v_r || s2_free;
  assign in_item.ready = s1_free;
  assign in_acc  = in_item.valid && s1_free;

  assign wait_diff      = next_r - in_item.now_ticks;
  assign late_diff      = in_item.now_ticks - next_r;
  assign now_plus_step  = in_item.now_ticks + step_r;
  assign next_plus_step = next_r + step_r;
  assign is_wait        = !in_item.restart && (wait_diff < step_r);
  assign in_cadence     = late_diff <= step_r;
  assign advance        = !in_item.restart && !is_wait;

  always_comb begin
    frame_clock_nxt = frame_clock_r;
    next_nxt        = next_r;
    mark_nxt        = mark_r;
    jerks_nxt       = jerks_r;
    priority if (in_item.restart) begin
      frame_clock_nxt = in_item.now_ticks;
      next_nxt        = now_plus_step;
      mark_nxt        = in_item.now_ticks;
      jerks_nxt       = '0;
    end else if (is_wait) begin
      // Waiting leaves the clock and the mark where they are.
    end else if (in_cadence) begin
      frame_clock_nxt = next_r;
      next_nxt        = next_plus_step;
      mark_nxt        = in_item.now_ticks;
    end else begin
      frame_clock_nxt = in_item.now_ticks;
      next_nxt        = now_plus_step;
      mark_nxt        = in_item.now_ticks;
      if (jerks_r != JERK_MAX) begin
        jerks_nxt = jerks_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r        <= '0;
      k_r           <= '0;
      frame_clock_r <= '0;
      next_r        <= '0;
      mark_r        <= '0;
      jerks_r       <= '0;
    end else if (in_acc) begin
      frame_clock_r <= frame_clock_nxt;
      next_r        <= next_nxt;
      mark_r        <= mark_nxt;
      jerks_r       <= jerks_nxt;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_STEP: begin
          step_r <= cfg_data;
          next_r <= frame_clock_r + cfg_data;
        end
        CFG_USEC_PER_TICK: begin
          k_r <= cfg_data[K_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_r <= in_item.valid;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_free) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_adv_r     <= advance;
      s1_jerk_r    <= jerks_nxt;
      // A zero delta makes the sleep time zero whenever the block is not waiting.
      s1_sleep_d_r <= is_wait ? wait_diff : '0;
      s1_elap_d_r  <= in_item.now_ticks - mark_r;
    end
    if (s2_free && s1_v_r) begin
      s2_adv_r  <= s1_adv_r;
      s2_jerk_r <= s1_jerk_r;
    end
    if (s3_free && s2_v_r) begin
      out_adv_r  <= s2_adv_r;
      out_jerk_r <= s2_jerk_r;
    end
  end

  assign conv_ctl.pp_en  = s2_free && s1_v_r;
  assign conv_ctl.out_en = s3_free && s2_v_r;

  fsfp_usec_conv u_sleep_conv (
    .clk           (clk),
    .ctl           (conv_ctl),
    .delta         (s1_sleep_d_r),
    .usec_per_tick (k_r),
    .usec          (sleep_usec)
  );

  fsfp_usec_conv u_elapsed_conv (
    .clk           (clk),
    .ctl           (conv_ctl),
    .delta         (s1_elap_d_r),
    .usec_per_tick (k_r),
    .usec          (elapsed_usec)
  );

  assign out_result.valid        = out_v_r;
  assign out_result.advanced     = out_adv_r;
  assign out_result.sleep_usec   = sleep_usec;
  assign out_result.elapsed_usec = elapsed_usec;
  assign out_result.jerk_count   = out_jerk_r;

  a_next_tracks_clock: assert property (@(posedge clk) disable iff (!rst_n)
    next_r == frame_clock_r + step_r)
    else $error("precomputed next frame time out of step with the clock");

  a_restart_clears_jerks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_item.restart |=> jerks_r == '0)
    else $error("restart did not clear the jerk count");

  a_jerks_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && in_item.restart) |=> jerks_r >= $past(jerks_r))
    else $error("jerk count decreased without a restart");

  a_wait_holds_clock: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_wait |=> $stable(frame_clock_r) && $stable(mark_r))
    else $error("waiting transaction moved the frame clock or mark");

  a_pipe_advances: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !out_v_r |=> out_v_r)
    else $error("result stage failed to load from the multiplier stage");

endmodule

[tb/tb_fixed_step_frame_pacer.sv]
`timescale 1ns / 1ps

module tb_fixed_step_frame_pacer;
  import fsfp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;
  localparam int DRAIN_CYCLES    = 4;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_ITEMS     = 150;
  localparam int NUM_PHASES      = 9;
  localparam logic [TICK_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic              advanced;
    logic [USEC_W-1:0] sleep_us;
    logic [USEC_W-1:0] elapsed_us;
    logic [JERK_W-1:0] jerks;
  } frame_result_t;

  // A row is either a transaction checked by the predictor, a transaction with
  // its result written out here, or a register write.
  typedef enum logic [1:0] {ROW_ITEM, ROW_KNOWN, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic                 restart;
    logic [TICK_W-1:0]    value;
    logic [CFG_IDX_W-1:0] reg_idx;
    frame_result_t        known;
  } stim_row_t;

  localparam frame_result_t NONE = '0;

  localparam stim_row_t DIRECTED [25] = '{
    // Zero step and zero scale right after reset.
    '{ROW_KNOWN, 1'b0, 64'd0, CFG_FRAME_STEP, '{1'b1, 31'd0, 31'd0, 32'd0}},
    '{ROW_KNOWN, 1'b0, 64'd5, CFG_FRAME_STEP, '{1'b1, 31'd0, 31'd0, 32'd1}},
    '{ROW_KNOWN, 1'b0, ALL_ONES, CFG_FRAME_STEP, '{1'b1, 31'd0, 31'd0, 32'd2}},
    '{ROW_KNOWN, 1'b1, ALL_ONES, CFG_FRAME_STEP, '{1'b0, 31'd0, 31'd0, 32'd0}},
    // Upper bits of the scale write fall away, leaving exactly one.
    '{ROW_CFG, 1'b0, 64'hFFFF_FFFE_0000_0000, CFG_USEC_PER_TICK, NONE},
    '{ROW_CFG, 1'b0, 64'd1000, CFG_FRAME_STEP, NONE},
    '{ROW_CFG, 1'b0, ALL_ONES, CFG_UNUSED_LO, NONE},
    '{ROW_CFG, 1'b0, 64'h5555_5555_5555_5555, CFG_UNUSED_HI, NONE},
    '{ROW_ITEM, 1'b1, 64'd0, CFG_FRAME_STEP, NONE},
    '{ROW_ITEM, 1'b0, 64'd500, CFG_FRAME_STEP, NONE},
    '{ROW_ITEM, 1'b0, 64'd1000, CFG_FRAME_STEP, NONE},
    '{ROW_ITEM, 1'b0, 64'd1001, CFG_FRAME_STEP, NONE},
    '{ROW_ITEM, 1'b0, 64'd3001, CFG_FRAME_STEP, NONE},
    '{ROW_ITEM, 1'b0, 64'd4001, CFG_FRAME_STEP, NONE},
    '{ROW_ITEM, 1'b0, 64'd5001, CFG_FRAME_STEP, NONE},
    '{ROW_ITEM, 1'b0, 64'd6002, CFG_FRAME_STEP, NONE},
    // The tick counter wraps between these two transactions.
    '{ROW_ITEM, 1'b1, 64'hFFFF_FFFF_FFFF_FF9C, CFG_FRAME_STEP, NONE},
    '{ROW_ITEM, 1'b0, 64'd850, CFG_FRAME_STEP, NONE},
    '{ROW_ITEM, 1'b0, 64'd901, CFG_FRAME_STEP, NONE},
    '{ROW_CFG, 1'b0, ALL_ONES, CFG_FRAME_STEP, NONE},
    '{ROW_CFG, 1'b0, 64'd1, CFG_USEC_PER_TICK, NONE},
    '{ROW_ITEM, 1'b1, 64'd12345, CFG_FRAME_STEP, NONE},
    '{ROW_ITEM, 1'b0, 64'd12345, CFG_FRAME_STEP, NONE},
    '{ROW_ITEM, 1'b0, 64'd0, CFG_FRAME_STEP, NONE},
    '{ROW_ITEM, 1'b0, ALL_ONES, CFG_FRAME_STEP, NONE}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TICK_W-1:0]    cfg_data;

  fsfp_in_if  in_if ();
  fsfp_out_if out_if ();

  fixed_step_frame_pacer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_if),
    .out_result (out_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Pacer state as the predictor sees it.
  logic [TICK_W-1:0] pace_clock = '0;
  logic [TICK_W-1:0] pace_mark  = '0;
  logic [JERK_W-1:0] pace_jerks = '0;
  logic [TICK_W-1:0] cfg_step   = '0;
  logic [K_W-1:0]    cfg_usec_k = '0;

  frame_result_t pending_results [$];
  int            fail_count    = 0;
  bit            tx_quiet      = 1'b0;
  bit            rx_quiet      = 1'b0;
  int            hold_requests = 0;
  int            hold_served   = 0;
  bit            rx_level      = 1'b0;
  int            rx_run        = 0;

  function automatic logic [USEC_W-1:0] to_usec(logic [TICK_W-1:0] delta);
    logic [TICK_W-1:0] prod;
    prod = delta * {{(TICK_W-K_W){1'b0}}, cfg_usec_k};
    return prod[TICK_W-1:FRAC_SHIFT];
  endfunction

  function automatic frame_result_t pace_frame(logic [TICK_W-1:0] now, logic restart);
    frame_result_t     r;
    logic [TICK_W-1:0] next_t;
    r = '0;
    r.elapsed_us = to_usec(now - pace_mark);
    if (restart) begin
      pace_clock = now;
      pace_mark  = now;
      pace_jerks = '0;
    end else begin
      next_t = pace_clock + cfg_step;
      if (next_t - now < cfg_step) begin
        r.sleep_us = to_usec(next_t - now);
      end else begin
        if (now - next_t <= cfg_step) begin
          pace_clock = next_t;
        end else begin
          pace_clock = now;
          if (pace_jerks != '1) pace_jerks = pace_jerks + 1'b1;
        end
        pace_mark  = now;
        r.advanced = 1'b1;
      end
    end
    r.jerks = pace_jerks;
    return r;
  endfunction

  function automatic logic [TICK_W-1:0] rand_ticks();
    return {$urandom, $urandom};
  endfunction

  // Timestamps placed around the next frame time (waiting, on cadence, late) or drawn at random.
  function automatic logic [TICK_W-1:0] pick_now();
    logic [TICK_W-1:0] next_t;
    int                sel;
    next_t = pace_clock + cfg_step;
    sel    = $urandom_range(0, 99);
    if (cfg_step == '0) begin
      return (sel < 50) ? pace_clock : pace_clock + $urandom_range(1, 1000);
    end
    if (sel < 20) begin
      case ($urandom_range(0, 6))
        0: return next_t - cfg_step;
        1: return next_t - cfg_step + 1'b1;
        2: return next_t - 1'b1;
        3: return next_t;
        4: return next_t + 1'b1;
        5: return next_t + cfg_step;
        default: return next_t + cfg_step + 1'b1;
      endcase
    end
    if (sel < 50) return next_t - rand_ticks() % cfg_step;
    if (sel < 82) begin
      if (cfg_step == '1) return next_t + rand_ticks();
      return next_t + rand_ticks() % (cfg_step + 1'b1);
    end
    if (sel < 92) return next_t + cfg_step + 1'b1 + $urandom_range(0, 999);
    return rand_ticks();
  endfunction

  function automatic int sender_gap();
    int r;
    if (tx_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int stall_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 2);
    if (r < 97) return $urandom_range(3, 10);
    return $urandom_range(20, 50);
  endfunction

  task automatic offer(input logic [TICK_W-1:0] now, input logic restart,
                       input bit use_known, input frame_result_t known);
    frame_result_t pred;
    in_if.valid     <= 1'b1;
    in_if.now_ticks <= now;
    in_if.restart   <= restart;
    do @(posedge clk); while (!in_if.ready);
    pred = pace_frame(now, restart);
    pending_results.push_back(use_known ? known : pred);
  endtask

  task automatic pause();
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Register writes happen only once the pipeline has drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FRAME_STEP:    cfg_step = data;
      CFG_USEC_PER_TICK: cfg_usec_k = data[K_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input int n_items);
    int                r;
    logic [TICK_W-1:0] now;
    logic              restart;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        now     = rand_ticks();
        restart = $urandom_range(0, 1);
      end else if (r < 11) begin
        now     = rand_ticks();
        restart = 1'b1;
      end else begin
        now     = pick_now();
        restart = 1'b0;
      end
      offer(now, restart, 1'b0, NONE);
      pause();
    end
  endtask

  task automatic check_result(input logic adv, input logic [USEC_W-1:0] sleep_us,
                              input logic [USEC_W-1:0] elapsed_us,
                              input logic [JERK_W-1:0] jerks);
    frame_result_t exp_r;
    if (pending_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: result with nothing pending: adv %0b sleep %0d elapsed %0d jerks %0d",
                 $realtime, adv, sleep_us, elapsed_us, jerks);
    end else begin
      exp_r = pending_results.pop_front();
      if (adv !== exp_r.advanced || sleep_us !== exp_r.sleep_us ||
          elapsed_us !== exp_r.elapsed_us || jerks !== exp_r.jerks) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: mismatch exp/got adv %0b/%0b sleep %0d/%0d elapsed %0d/%0d jerks %0d/%0d",
                   $realtime, exp_r.advanced, adv, exp_r.sleep_us, sleep_us,
                   exp_r.elapsed_us, elapsed_us, exp_r.jerks, jerks);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL fixed_step_frame_pacer");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      check_result(out_if.advanced, out_if.sleep_usec, out_if.elapsed_usec,
                   out_if.jerk_count);
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  initial begin : rx
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        rx_level    = 1'b0;
        rx_run      = HOLD_OFF_CYCLES;
      end else if (rx_run > 0) begin
        rx_run--;
      end else if (rx_quiet) begin
        rx_level = 1'b1;
      end else begin
        rx_level = !rx_level;
        rx_run   = rx_level ? $urandom_range(0, 15) : stall_cycles();
      end
      out_if.ready <= rx_level;
    end
  end

  initial begin : stim
    stim_row_t         row;
    logic [TICK_W-1:0] step_v;
    logic [TICK_W-1:0] k_v;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.now_ticks <= '0;
    in_if.restart   <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_FRAME_STEP;
    cfg_data        <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      if (row.kind == ROW_CFG) begin
        write_reg(row.reg_idx, row.value);
      end else begin
        offer(row.value, row.restart, row.kind == ROW_KNOWN, row.known);
        pause();
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
      k_v      = rand_ticks();
      case (p)
        0: begin
          step_v = $urandom_range(1, 40);
          k_v    = 64'h2_0000_0000;
        end
        1: step_v = '0;
        2: step_v = '1;
        3: step_v = rand_ticks();
        4: step_v = $urandom_range(100, 100000);
        5: begin
          step_v = 64'd1;
          k_v    = 64'd1;
        end
        6: begin
          step_v = {32'd0, $urandom};
          k_v    = '0;
        end
        7: step_v = $urandom_range(2, 8);
        default: step_v = rand_ticks() >> 16;
      endcase
      if ($urandom_range(0, 1))
        write_reg($urandom_range(0, 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI, rand_ticks());
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_FRAME_STEP, step_v);
        write_reg(CFG_USEC_PER_TICK, k_v);
      end else begin
        write_reg(CFG_USEC_PER_TICK, k_v);
        write_reg(CFG_FRAME_STEP, step_v);
      end
      if (p == 4) begin
        // The sender keeps offering at full rate while the result side is held off.
        tx_quiet = 1'b1;
        hold_requests++;
      end else if (p == 7) begin
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
      end
      run_phase(PHASE_ITEMS);
    end

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS fixed_step_frame_pacer");
    end else begin
      $display("FAIL fixed_step_frame_pacer");
    end
    $finish;
  end

endmodule
